/* rtl/sm4c_pkg.sv */
// ----------------------------------------------------------------------------
// SM4 CBC package
// Shared payload types, S-box, key constants and state codes.
// ----------------------------------------------------------------------------
package sm4c_pkg;

	localparam int unsigned RoundNum = 32;
	localparam int unsigned RkAddrW = 5;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_W0 = 3'd0,
		REG_KEY_W1 = 3'd1,
		REG_KEY_W2 = 3'd2,
		REG_KEY_W3 = 3'd3,
		REG_IV_HI = 3'd4,
		REG_IV_LO = 3'd5,
		REG_DECRYPT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] data_hi;
		logic [63:0] data_lo;
		logic        final_block;
		logic [4:0]  valid_bytes;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_hi;
		logic [63:0] out_lo;
		logic        last;
		logic [4:0]  strip_count;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEYEXP,
		ST_LOAD,
		ST_ROUND,
		ST_DONE,
		ST_OUT
	} state_t;

	localparam logic [31:0] FK0 = 32'hA3B1BAC6;
	localparam logic [31:0] FK1 = 32'h56AA3350;
	localparam logic [31:0] FK2 = 32'h677D9197;
	localparam logic [31:0] FK3 = 32'hB27022DC;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] subst_word(input logic [31:0] x);
		subst_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	function automatic logic [31:0] t_data(input logic [31:0] x);
		logic [31:0] b;
		b = subst_word(x);
		t_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
			^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

	function automatic logic [31:0] t_key(input logic [31:0] x);
		logic [31:0] b;
		b = subst_word(x);
		t_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

	// CK byte j of word i is (4i + j) * 7 mod 256
	function automatic logic [31:0] ck_word(input logic [RkAddrW-1:0] i);
		logic [7:0] base;
		base = {1'b0, i, 2'b00} * 8'd7;
		ck_word = {base, base + 8'd7, base + 8'd14, base + 8'd21};
	endfunction

endpackage

/* rtl/sm4_cbc_cipher.sv */
// ----------------------------------------------------------------------------
// SM4 CBC cipher
// 128-bit SM4 in CBC mode, PKCS#7 pad on encrypt, pad check on decrypt.
// ----------------------------------------------------------------------------
// Usage: input blocks transfer on in_valid/in_ready, results on
// out_valid/out_ready. Configuration is written through cfg_we/cfg_idx/
// cfg_data; the user must write it only while idle, as the block does not
// enforce this. It is sampled when the first block of a message is taken.
// The first block of a message first runs a key expansion that writes
// the round keys into a 32-entry RAM. Each block then passes a load
// state, the rounds (one registered RAM read per round) and a finish
// state; the next block can transfer only once the block is back in
// idle. A full final encrypt block produces a second padding block.
// The result sits in an output register; while the receiver stalls the
// block holds and accepts no new block. A new block is taken in the
// same cycle a result transfers.
// Reset clears control state, chain value and configuration; the round
// key RAM is not cleared and is always written before use.
// ----------------------------------------------------------------------------
module sm4_cbc_cipher
	import sm4c_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data
);

	logic [31:0] key_q [4];
	logic [63:0] iv_hi_q, iv_lo_q;
	logic        mode_q;

	logic [31:0] rk_mem [RoundNum];
	logic [31:0] rk_rd_q;
	logic        rk_we;
	logic [RkAddrW-1:0] rk_waddr, rk_raddr;
	logic [31:0] rk_wdata;

	state_t state_q, state_d;
	logic [RkAddrW-1:0] cnt_q;
	logic [31:0] x_q [4];
	logic [63:0] chain_hi_q, chain_lo_q;
	logic [63:0] cin_hi_q, cin_lo_q;
	logic        in_msg_q, dec_q, fin_q, extra_q, pad_blk_q;
	out_item_t   out_q;
	logic        out_valid_q;
	in_item_t    blk_q;

	logic take, out_fire;
	logic [31:0] knew, xnew;
	logic [63:0] res_hi, res_lo;
	logic [127:0] padded;
	logic [4:0] vb;
	logic [7:0] pbyte;

	assign out_fire = out_valid_q && out_ready;
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign take = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '{default: '0};
			iv_hi_q <= '0;
			iv_lo_q <= '0;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KEY_W0: key_q[0] <= cfg_data[31:0];
				REG_KEY_W1: key_q[1] <= cfg_data[31:0];
				REG_KEY_W2: key_q[2] <= cfg_data[31:0];
				REG_KEY_W3: key_q[3] <= cfg_data[31:0];
				REG_IV_HI: iv_hi_q <= cfg_data;
				REG_IV_LO: iv_lo_q <= cfg_data;
				REG_DECRYPT: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key schedule: x_q holds k[i..i+3] during ST_KEYEXP
	assign knew = x_q[0] ^ t_key(x_q[1] ^ x_q[2] ^ x_q[3] ^ ck_word(cnt_q));
	assign xnew = x_q[0] ^ t_data(x_q[1] ^ x_q[2] ^ x_q[3] ^ rk_rd_q);

	assign rk_we = (state_q == ST_KEYEXP);
	assign rk_waddr = dec_q ? ~cnt_q : cnt_q;
	assign rk_wdata = knew;
	// prefetch key for next round
	assign rk_raddr = (state_q == ST_LOAD) ? '0 : cnt_q + 1'b1;

	always_ff @(posedge clk) begin
		if (rk_we) begin
			rk_mem[rk_waddr] <= rk_wdata;
		end
		rk_rd_q <= rk_mem[rk_raddr];
	end

	// PKCS#7 padding of a final encrypt block
	always_comb begin
		vb = (blk_q.valid_bytes > 5'd16) ? 5'd16 : blk_q.valid_bytes;
		padded = {blk_q.data_hi, blk_q.data_lo};
		for (int b = 0; b < 16; b++) begin
			if (5'(b) >= vb) begin
				padded[(15-b)*8 +: 8] = 8'(5'd16 - vb);
			end
		end
		if (pad_blk_q) begin
			padded = {16{8'h10}};
		end else if (dec_q || !blk_q.final_block) begin
			padded = {blk_q.data_hi, blk_q.data_lo};
		end
	end

	assign res_hi = {x_q[3], x_q[2]} ^ (dec_q ? chain_hi_q : 64'd0);
	assign res_lo = {x_q[1], x_q[0]} ^ (dec_q ? chain_lo_q : 64'd0);
	assign pbyte = res_lo[7:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (take) state_d = in_msg_q ? ST_LOAD : ST_KEYEXP;
			ST_KEYEXP: if (cnt_q == 5'(RoundNum - 1)) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_ROUND;
			ST_ROUND: if (cnt_q == 5'(RoundNum - 1)) state_d = ST_DONE;
			ST_DONE: state_d = extra_q ? ST_OUT : ST_IDLE;
			ST_OUT: if (!out_valid_q || out_ready) state_d = ST_LOAD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			in_msg_q <= 1'b0;
			dec_q <= 1'b0;
			fin_q <= 1'b0;
			extra_q <= 1'b0;
			pad_blk_q <= 1'b0;
			out_valid_q <= 1'b0;
			chain_hi_q <= '0;
			chain_lo_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_fire) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					pad_blk_q <= 1'b0;
					if (take) begin
						fin_q <= in_data.final_block;
						if (!in_msg_q) begin
							in_msg_q <= 1'b1;
							dec_q <= mode_q;
							chain_hi_q <= iv_hi_q;
							chain_lo_q <= iv_lo_q;
							extra_q <= !mode_q && in_data.final_block
								&& (in_data.valid_bytes >= 5'd16);
						end else begin
							extra_q <= !dec_q && in_data.final_block
								&& (in_data.valid_bytes >= 5'd16);
						end
					end
				end
				ST_KEYEXP: cnt_q <= cnt_q + 1'b1;
				ST_LOAD: cnt_q <= '0;
				ST_ROUND: cnt_q <= cnt_q + 1'b1;
				ST_DONE: begin
					out_valid_q <= 1'b1;
					// message end: chain returns to the IV
					if (fin_q && !extra_q) begin
						chain_hi_q <= iv_hi_q;
						chain_lo_q <= iv_lo_q;
					end else if (dec_q) begin
						chain_hi_q <= cin_hi_q;
						chain_lo_q <= cin_lo_q;
					end else begin
						chain_hi_q <= res_hi;
						chain_lo_q <= res_lo;
					end
					if (extra_q) begin
						extra_q <= 1'b0;
						pad_blk_q <= 1'b1;
					end else if (fin_q) begin
						in_msg_q <= 1'b0;
					end
				end
				ST_OUT: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			blk_q <= in_data;
		end
		unique case (state_q)
			ST_IDLE: if (take) begin
				x_q[0] <= key_q[0] ^ FK0;
				x_q[1] <= key_q[1] ^ FK1;
				x_q[2] <= key_q[2] ^ FK2;
				x_q[3] <= key_q[3] ^ FK3;
			end
			ST_KEYEXP: begin
				x_q[0] <= x_q[1];
				x_q[1] <= x_q[2];
				x_q[2] <= x_q[3];
				x_q[3] <= knew;
			end
			ST_LOAD: begin
				cin_hi_q <= padded[127:64];
				cin_lo_q <= padded[63:0];
				if (dec_q) begin
					{x_q[0], x_q[1], x_q[2], x_q[3]} <= padded;
				end else begin
					{x_q[0], x_q[1], x_q[2], x_q[3]} <= padded
						^ {chain_hi_q, chain_lo_q};
				end
			end
			ST_ROUND: begin
				x_q[0] <= x_q[1];
				x_q[1] <= x_q[2];
				x_q[2] <= x_q[3];
				x_q[3] <= xnew;
			end
			ST_DONE: begin
				out_q.out_hi <= res_hi;
				out_q.out_lo <= res_lo;
				out_q.last <= fin_q && !extra_q;
				out_q.strip_count <= (dec_q && fin_q && pbyte >= 8'd1 && pbyte <= 8'd16)
					? pbyte[4:0] : 5'd0;
			end
			default: ;
		endcase
	end

endmodule
